>>> sv/ubd_pkg.sv
// ----------------------------------------------------------------------------
// UART baud divisor package
// Shared types, constants and prescaler decode functions for the baud
// divisor pipeline.
// ----------------------------------------------------------------------------
package ubd_pkg;

  localparam int unsigned ClkW   = 28;
  localparam int unsigned BaudW  = 24;
  localparam int unsigned DivW   = 16;
  localparam int unsigned WordW  = 32;

  localparam logic [ClkW-1:0] OscHz     = ClkW'(8000000);
  localparam logic [ClkW-1:0] HalfOscHz = ClkW'(4000000);

  localparam logic [1:0] SrcOscA = 2'd0;
  localparam logic [1:0] SrcOscB = 2'd1;
  localparam logic [1:0] SrcPll  = 2'd2;
  localparam logic [1:0] SrcOff  = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] clock_config_word;
    logic             apb2_select;
    logic [BaudW-1:0] baud_bps;
  } in_t;

  typedef struct packed {
    logic [ClkW-1:0] bus_clock_hz;
    logic [DivW-1:0] divisor;
    logic            zero_baud_error;
  } out_t;

  typedef struct packed {
    logic [ClkW-1:0]  num;
    logic [BaudW-1:0] den;
    logic [BaudW-1:0] rem;
    logic [DivW-1:0]  quo;
    logic [ClkW-1:0]  clk_hz;
    logic             err;
  } div_t;

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] sh;
    unique case (code)
      4'd8:    sh = 4'd1;
      4'd9:    sh = 4'd2;
      4'd10:   sh = 4'd3;
      4'd11:   sh = 4'd4;
      4'd12:   sh = 4'd6;
      4'd13:   sh = 4'd7;
      4'd14:   sh = 4'd8;
      4'd15:   sh = 4'd9;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] sh;
    unique case (code)
      3'd4:    sh = 3'd1;
      3'd5:    sh = 3'd2;
      3'd6:    sh = 3'd3;
      3'd7:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

>>> sv/ubd_div_stage.sv
// ----------------------------------------------------------------------------
// UART baud divisor restoring division step
// Retires one quotient bit per stage with a single compare and subtract.
// ----------------------------------------------------------------------------
module ubd_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ubd_pkg::div_t data_i,
  input  logic          num_bit_i,
  output logic          valid_o,
  output ubd_pkg::div_t data_o
);
  import ubd_pkg::*;

  logic [BaudW:0]   trial;
  logic             ge;
  logic [BaudW:0]   diff;
  div_t             data_d;

  always_comb begin
    trial  = {data_i.rem, num_bit_i};
    ge     = trial >= {1'b0, data_i.den};
    diff   = trial - {1'b0, data_i.den};
    data_d = data_i;
    data_d.rem = ge ? diff[BaudW-1:0] : trial[BaudW-1:0];
    data_d.quo = {data_i.quo[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

>>> sv/uart_clock_tree_baud_divisor_core.sv
// ----------------------------------------------------------------------------
// UART clock tree baud divisor core
// Decodes a clock configuration word into the peripheral bus clock and
// returns the rounded baud divisor.
//
//   Channel | Signals                              | Direction
//   in      | in_valid_i, in_ready_o, in_data_i    | consumer
//   out     | out_valid_o, out_ready_i, out_data_o | producer
//
// One transaction is accepted every cycle unless the pipeline is frozen.
// Each one passes through a decode stage, a numerator stage, the restoring
// divider, one quotient bit per stage over 28 stages, and the output
// register. Reset empties every stage.
// While the output holds a result that is not taken, the whole pipeline
// freezes and in_ready_o is low.
// ----------------------------------------------------------------------------
module uart_clock_tree_baud_divisor_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ubd_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ubd_pkg::out_t out_data_o
);
  import ubd_pkg::*;

  localparam int unsigned DivSteps = ClkW;

  logic            adv;
  logic [1:0]      src;
  logic [4:0]      pll_mul;
  logic [ClkW-1:0] pll_hz;
  logic [ClkW-1:0] base_hz;
  logic [ClkW-1:0] pre_hz;
  logic [ClkW-1:0] dec_hz;
  logic [2:0]      apb_code;

  logic             s0_valid_q;
  logic [ClkW-1:0]  s0_hz_q;
  logic [BaudW-1:0] s0_baud_q;
  div_t             s1_d;
  logic             s1_valid_q;
  div_t             s1_q;

  logic [DivSteps:0] div_valid;
  div_t              div_data [DivSteps+1];

  logic out_valid_q;
  out_t out_data_q;
  out_t out_data_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    src      = in_data_i.clock_config_word[3:2];
    pll_mul  = {1'b0, in_data_i.clock_config_word[21:18]} + 5'd2;
    pll_hz   = HalfOscHz * {{(ClkW-5){1'b0}}, pll_mul};
    if (in_data_i.clock_config_word[16] && !in_data_i.clock_config_word[17]) begin
      pll_hz = pll_hz << 1;
    end
    apb_code = in_data_i.apb2_select ? in_data_i.clock_config_word[13:11]
                                     : in_data_i.clock_config_word[10:8];
    base_hz  = (src == SrcPll) ? pll_hz : OscHz;
    pre_hz   = (base_hz >> ahb_shift(in_data_i.clock_config_word[7:4]))
               >> apb_shift(apb_code);
    unique case (src)
      SrcOscA, SrcOscB, SrcPll: dec_hz = pre_hz;
      SrcOff:                   dec_hz = '0;
      default:                  dec_hz = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_hz_q   <= dec_hz;
      s0_baud_q <= in_data_i.baud_bps;
    end
  end

  always_comb begin
    s1_d.num    = s0_hz_q + {{(ClkW-BaudW+1){1'b0}}, s0_baud_q[BaudW-1:1]};
    s1_d.den    = s0_baud_q;
    s1_d.rem    = '0;
    s1_d.quo    = '0;
    s1_d.clk_hz = s0_hz_q;
    s1_d.err    = (s0_baud_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
    end
  end

  assign div_valid[0] = s1_valid_q;
  assign div_data[0]  = s1_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    localparam int unsigned Bit = DivSteps - 1 - i;
    ubd_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .valid_i   (div_valid[i]),
      .data_i    (div_data[i]),
      .num_bit_i (div_data[i].num[Bit]),
      .valid_o   (div_valid[i+1]),
      .data_o    (div_data[i+1])
    );
  end

  always_comb begin
    out_data_d.bus_clock_hz    = div_data[DivSteps].clk_hz;
    out_data_d.divisor         = div_data[DivSteps].err ? '0 : div_data[DivSteps].quo;
    out_data_d.zero_baud_error = div_data[DivSteps].err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_err_zero_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.zero_baud_error) |-> (out_data_q.divisor == '0))
    else $error("zero baud rate produced a nonzero divisor");

  a_off_clk_zero_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.bus_clock_hz == '0)) |-> (out_data_q.divisor == '0))
    else $error("stopped clock produced a nonzero divisor");

  a_clk_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.bus_clock_hz <= ClkW'(136000000)))
    else $error("bus clock above the highest reachable frequency");

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(div_valid) && $stable(s0_valid_q))
    else $error("pipeline moved during a stall");
`endif

endmodule

>>> verif/uart_clock_tree_baud_divisor_core_tb.sv
// ----------------------------------------------------------------------------
// UART clock tree baud divisor core testbench
// Drives clock configuration queries through the valid/ready input channel,
// predicts the bus clock and the rounded baud divisor of each transaction,
// and checks every result in order. Both sides idle at random, and the
// receiver holds off long enough to back up the whole pipeline.
// ----------------------------------------------------------------------------
module uart_clock_tree_baud_divisor_core_tb;

  import ubd_pkg::*;

  class baud_result_tracker;
    out_t        pending_divisors[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned zero_baud_seen;
    int unsigned pll_seen;
    int unsigned clock_off_seen;
    int unsigned truncated_seen;

    function out_t derive_baud_divisor(in_t q);
      logic [31:0] w;
      logic [3:0]  ahb_code;
      logic [2:0]  apb_code;
      int unsigned ahb_sh;
      int unsigned apb_sh;
      logic [31:0] bus_hz;
      logic [63:0] quo;
      out_t        r;
      w        = q.clock_config_word;
      ahb_code = w[7:4];
      apb_code = q.apb2_select ? w[13:11] : w[10:8];
      ahb_sh   = (ahb_code < 8) ? 0 : (ahb_code < 12) ? ahb_code - 7 : ahb_code - 6;
      apb_sh   = (apb_code < 4) ? 0 : apb_code - 3;
      case (w[3:2])
        SrcPll: begin
          bus_hz = ((w[16] && !w[17]) ? 32'(OscHz) : 32'(HalfOscHz)) *
                   (32'(w[21:18]) + 32'd2);
          pll_seen++;
        end
        SrcOff: begin
          bus_hz = 32'd0;
          clock_off_seen++;
        end
        default: bus_hz = 32'(OscHz);
      endcase
      if (w[3:2] != SrcOff) begin
        bus_hz = (bus_hz >> ahb_sh) >> apb_sh;
      end
      r.bus_clock_hz = bus_hz[ClkW-1:0];
      if (q.baud_bps == '0) begin
        r.divisor         = '0;
        r.zero_baud_error = 1'b1;
        zero_baud_seen++;
      end else begin
        quo = (64'(bus_hz) + 64'(q.baud_bps >> 1)) / 64'(q.baud_bps);
        if (quo > 64'd65535) begin
          truncated_seen++;
        end
        r.divisor         = quo[DivW-1:0];
        r.zero_baud_error = 1'b0;
      end
      return r;
    endfunction

    function void note_query(in_t q);
      pending_divisors.push_back(derive_baud_divisor(q));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_divisors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result with nothing pending: clk=%0d div=%0d err=%0b",
                   got.bus_clock_hz, got.divisor, got.zero_baud_error);
        end
        return;
      end
      want = pending_divisors.pop_front();
      checked++;
      if (got.bus_clock_hz != want.bus_clock_hz || got.divisor != want.divisor ||
          got.zero_baud_error != want.zero_baud_error) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result %0d: expected clk=%0d div=%0d err=%0b, got clk=%0d div=%0d err=%0b",
                   checked, want.bus_clock_hz, want.divisor, want.zero_baud_error,
                   got.bus_clock_hz, got.divisor, got.zero_baud_error);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_divisors.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  baud_result_tracker tracker;
  bit                 no_idle;
  bit                 hold_req;
  int unsigned        sent;

  uart_clock_tree_baud_divisor_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.note_query(in_data);
      end
      if (out_valid && out_ready) begin
        tracker.check_result(out_data);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] make_word(logic [1:0] src, logic [3:0] ahb,
                                            logic [2:0] apb_lo, logic [2:0] apb_hi,
                                            int unsigned pll_src, int unsigned pll_half,
                                            logic [3:0] mul, int unsigned junk);
    logic [31:0] w;
    w = (junk != 0) ? $urandom : 32'd0;
    w[3:2]   = src;
    w[7:4]   = ahb;
    w[10:8]  = apb_lo;
    w[13:11] = apb_hi;
    w[16]    = pll_src[0];
    w[17]    = pll_half[0];
    w[21:18] = mul;
    return w;
  endfunction

  function automatic in_t random_query();
    in_t         q;
    int unsigned r;
    q.clock_config_word = $urandom;
    if ($urandom_range(0, 99) < 40) begin
      q.clock_config_word = make_word(2'($urandom_range(0, 2)), 4'($urandom),
                                      3'($urandom), 3'($urandom),
                                      $urandom_range(0, 1), $urandom_range(0, 1),
                                      4'($urandom), $urandom_range(0, 1));
    end
    q.apb2_select = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      q.baud_bps = '0;
    end else if (r < 20) begin
      q.baud_bps = BaudW'($urandom_range(1, 64));
    end else if (r < 32) begin
      q.baud_bps = BaudW'($urandom);
    end else if (r < 36) begin
      q.baud_bps = 24'hFFFFFF - BaudW'($urandom_range(0, 15));
    end else begin
      q.baud_bps = BaudW'($urandom_range(300, 4000000));
    end
    return q;
  endfunction

  task automatic send_query(input in_t q);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= q;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_query(random_query());
  endtask

  task automatic wait_drained();
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  initial begin : receiver
    int unsigned stall_cnt;
    stall_cnt = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_cnt > 0) begin
        out_ready <= 1'b0;
        stall_cnt--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25) begin
          stall_cnt = pick_gap();
        end
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    in_t directed_q[$];
    tracker  = new();
    no_idle  = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_q.push_back('{32'h0000_0000, 1'b0, 24'd0});
    directed_q.push_back('{32'hFFFF_FFFF, 1'b1, 24'hFFFFFF});
    directed_q.push_back('{32'hFFFF_FFFF, 1'b0, 24'd1});
    directed_q.push_back('{make_word(SrcOscA, 4'd15, 3'd7, 3'd0, 0, 0, 4'd0, 0), 1'b0, 24'd1});
    directed_q.push_back('{make_word(SrcOscB, 4'd8, 3'd0, 3'd7, 0, 0, 4'd0, 0), 1'b1, 24'd9600});
    directed_q.push_back('{make_word(SrcOscB, 4'd7, 3'd3, 3'd4, 0, 0, 4'd0, 0), 1'b0, 24'd2});
    directed_q.push_back('{make_word(SrcOscA, 4'd0, 3'd0, 3'd0, 0, 0, 4'd0, 0), 1'b0, 24'd1});
    directed_q.push_back('{make_word(SrcPll, 4'd0, 3'd0, 3'd0, 1, 0, 4'd15, 0), 1'b0, 24'd1});
    directed_q.push_back('{make_word(SrcPll, 4'd0, 3'd0, 3'd0, 1, 0, 4'd15, 0), 1'b1, 24'd0});
    directed_q.push_back('{make_word(SrcPll, 4'd12, 3'd5, 3'd6, 0, 0, 4'd0, 0), 1'b0, 24'd115200});
    directed_q.push_back('{make_word(SrcPll, 4'd12, 3'd5, 3'd6, 0, 1, 4'd0, 0), 1'b1, 24'd115200});
    directed_q.push_back('{make_word(SrcPll, 4'd9, 3'd1, 3'd2, 1, 1, 4'd7, 0), 1'b0, 24'hFFFFFF});
    directed_q.push_back('{make_word(SrcPll, 4'd11, 3'd7, 3'd7, 1, 0, 4'd7, 0), 1'b1, 24'd3});
    directed_q.push_back('{make_word(SrcOff, 4'd0, 3'd0, 3'd0, 1, 0, 4'd15, 0), 1'b0, 24'd1});
    directed_q.push_back('{make_word(SrcOff, 4'd15, 3'd7, 3'd7, 1, 0, 4'd15, 0), 1'b1, 24'hFFFFFF});
    directed_q.push_back('{32'hFFC0_C003 | make_word(SrcOscA, 4'd10, 3'd6, 3'd4, 0, 0, 4'd0, 0),
                           1'b0, 24'd4800});
    directed_q.push_back('{32'hFFC0_C003 | make_word(SrcPll, 4'd13, 3'd4, 3'd5, 1, 0, 4'd3, 0),
                           1'b1, 24'd57600});
    directed_q.push_back('{make_word(SrcPll, 4'd14, 3'd0, 3'd7, 1, 0, 4'd15, 0), 1'b1, 24'd16});
    directed_q.push_back('{make_word(SrcPll, 4'd15, 3'd7, 3'd0, 1, 0, 4'd15, 0), 1'b1, 24'd1});
    directed_q.push_back('{32'h5555_5555, 1'b0, 24'h555555});
    directed_q.push_back('{32'hAAAA_AAAA, 1'b1, 24'hAAAAAA});
    foreach (directed_q[i]) begin
      send_query(directed_q[i]);
    end

    in_valid <= 1'b0;
    wait_drained();

    hold_req = 1'b1;
    no_idle  = 1'b1;
    send_random(80);
    no_idle  = 1'b0;
    send_random(340);

    in_valid <= 1'b0;
    wait_drained();

    no_idle = 1'b1;
    send_random(350);
    no_idle = 1'b0;
    send_random(360);

    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(negedge clk);

    $display("Ran %0d queries, %0d checked: %0d zero baud, %0d PLL, %0d clock off.",
             sent, tracker.checked, tracker.zero_baud_seen, tracker.pll_seen,
             tracker.clock_off_seen);
    $display("Divisors wrapped past 16 bits: %0d; mismatches: %0d.",
             tracker.truncated_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ubd_pkg.sv
sv/ubd_div_stage.sv
sv/uart_clock_tree_baud_divisor_core.sv
verif/uart_clock_tree_baud_divisor_core_tb.sv
